[sv/msp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned DataW   = 7;
  localparam int unsigned ChanW   = 4;
  localparam int unsigned CountW  = 2;
  localparam int unsigned OutTdataW = 32;

  localparam logic [4:0] RealTimePrefix = 5'b11111;
  localparam logic [3:0] SystemNibble   = 4'hF;

  localparam logic [ByteW-1:0] StSysex      = 8'hF0;
  localparam logic [ByteW-1:0] StProgChange = 8'hC0;
  localparam logic [ByteW-1:0] StChanPress  = 8'hD0;
  localparam logic [ByteW-1:0] StTimeCode   = 8'hF1;
  localparam logic [ByteW-1:0] StSongSelect = 8'hF3;
  localparam logic [ByteW-1:0] StNoteOff    = 8'h80;
  localparam logic [ByteW-1:0] StNoteOn     = 8'h90;
  localparam logic [ByteW-1:0] StPolyPress  = 8'hA0;
  localparam logic [ByteW-1:0] StControl    = 8'hB0;
  localparam logic [ByteW-1:0] StPitchBend  = 8'hE0;
  localparam logic [ByteW-1:0] StSongPos    = 8'hF2;

  localparam logic [CountW-1:0] CountNone = 2'd0;
  localparam logic [CountW-1:0] CountOne  = 2'd1;
  localparam logic [CountW-1:0] CountTwo  = 2'd2;

  typedef struct packed {
    logic [DataW-1:0]  second_data;
    logic [DataW-1:0]  first_data;
    logic [CountW-1:0] data_count;
    logic [ChanW-1:0]  channel;
    logic [ByteW-1:0]  event_code;
  } msp_event_t;

  function automatic logic is_one_group(input logic [ByteW-1:0] key);
    return (key == StProgChange) || (key == StChanPress) ||
           (key == StTimeCode) || (key == StSongSelect);
  endfunction

  function automatic logic is_two_group(input logic [ByteW-1:0] key);
    return (key == StNoteOff) || (key == StNoteOn) || (key == StPolyPress) ||
           (key == StControl) || (key == StPitchBend) || (key == StSongPos);
  endfunction

  function automatic msp_event_t make_event(input logic [ByteW-1:0]  status,
                                            input logic [CountW-1:0] count,
                                            input logic [DataW-1:0]  d1,
                                            input logic [DataW-1:0]  d2);
    msp_event_t ev;
    logic       sys;
    sys = (status[7:4] == SystemNibble);
    ev.event_code  = sys ? status : {status[7:4], 4'h0};
    ev.channel     = sys ? 4'h0 : status[3:0];
    ev.data_count  = count;
    ev.first_data  = d1;
    ev.second_data = d2;
    return ev;
  endfunction

endpackage

`default_nettype wire

[sv/midi_stream_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

// MIDI byte stream parser. One byte is taken per cycle on the slave side and
// each complete message (or real-time byte) comes out as one event on the
// master side in the cycle after its last byte is taken. Running status is
// kept for channel and system common messages; SysEx data bytes and data
// bytes without a valid status are dropped. Throughput is one byte per
// cycle, set by the single output register: input stalls only when that
// register holds an event the master side has not taken.
module midi_stream_parser
  import msp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [ByteW-1:0]     s_axis_tdata,  // [7:0] rx_byte
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [7:0] event_code, [11:8] channel, [13:12] data_count,
  // [20:14] first_data, [27:21] second_data, [31:28] zero
  output logic [OutTdataW-1:0]      m_axis_tdata
);

  logic       in_txn;
  logic       res_valid;
  msp_event_t res;
  msp_event_t out_ev;

  assign in_txn = s_axis_tvalid && s_axis_tready;

  msp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_txn),
    .rx_byte_i   (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  msp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_txn),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_ready_i (m_axis_tready),
    .can_load_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_o       (out_ev)
  );

  assign m_axis_tdata = {{(OutTdataW - $bits(msp_event_t)){1'b0}}, out_ev};

`ifndef SYNTHESIS
  a_realtime_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_txn && s_axis_tdata[7:3] == RealTimePrefix) |=> m_axis_tvalid)
    else $error("real-time byte did not produce an event");

  a_status_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_txn && s_axis_tdata[7] && s_axis_tdata[7:3] != RealTimePrefix)
      |=> !m_axis_tvalid)
    else $error("status byte produced an event");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[13:12] != 2'd3)
    else $error("data count out of range");

  a_system_no_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[7:4] == SystemNibble) |-> m_axis_tdata[11:8] == 4'h0)
    else $error("system event carries a channel");
`endif

endmodule

`default_nettype wire

[sv/msp_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module msp_parser
  import msp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [ByteW-1:0]  rx_byte_i,
  output logic                   res_valid_o,
  output msp_event_t             res_o
);

  typedef enum logic [2:0] {
    PhWait  = 3'd0,
    PhOne   = 3'd1,
    PhTwoA  = 3'd2,
    PhTwoB  = 3'd3,
    PhSysex = 3'd4
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  held_status_q, held_status_d;
  logic [DataW-1:0]  held_first_q, held_first_d;

  logic              real_time;
  logic [ByteW-1:0]  key;

  assign real_time = (rx_byte_i[7:3] == RealTimePrefix);
  assign key = (rx_byte_i[7:4] == SystemNibble) ? rx_byte_i : {rx_byte_i[7:4], 4'h0};

  always_comb begin
    phase_d       = phase_q;
    held_status_d = held_status_q;
    held_first_d  = held_first_q;
    res_valid_o   = 1'b0;
    res_o         = make_event(rx_byte_i, CountNone, '0, '0);
    if (real_time) begin
      // real-time bytes leave the parse state alone
      res_valid_o = 1'b1;
    end else if (rx_byte_i[7]) begin
      held_status_d = rx_byte_i;
      if (is_one_group(key)) begin
        phase_d = PhOne;
      end else if (is_two_group(key)) begin
        phase_d = PhTwoA;
      end else if (rx_byte_i == StSysex) begin
        phase_d = PhSysex;
      end else begin
        // undefined status drops running status
        phase_d = PhWait;
      end
    end else begin
      case (phase_q)
        PhOne: begin
          res_valid_o = 1'b1;
          res_o = make_event(held_status_q, CountOne, rx_byte_i[DataW-1:0], '0);
        end
        PhTwoA: begin
          held_first_d = rx_byte_i[DataW-1:0];
          phase_d      = PhTwoB;
        end
        PhTwoB: begin
          res_valid_o = 1'b1;
          res_o = make_event(held_status_q, CountTwo, held_first_q,
                             rx_byte_i[DataW-1:0]);
          phase_d = PhTwoA;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhWait;
      held_status_q <= '0;
      held_first_q  <= '0;
    end else if (accept_i) begin
      phase_q       <= phase_d;
      held_status_q <= held_status_d;
      held_first_q  <= held_first_d;
    end
  end

endmodule

`default_nettype wire

[sv/msp_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module msp_out_reg
  import msp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         load_i,
  input  wire logic         res_valid_i,
  input  wire msp_event_t   res_i,
  input  wire logic         out_ready_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  output msp_event_t        out_o
);

  logic       valid_q;
  msp_event_t data_q;

  // slot frees up in the same cycle its content is taken
  assign can_load_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_valid_i;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule

`default_nettype wire
